/* design/tick_timers_and_button_classifier_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tick timers and button classifier.
// Each macro expands to one labeled concurrent assertion clocked on i_clk
// and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_TIMERS_AND_BUTTON_CLASSIFIER_MACROS_SVH
`define TICK_TIMERS_AND_BUTTON_CLASSIFIER_MACROS_SVH

// Same-cycle implication
`define TTBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ttbc assertion failed");

// Next-cycle implication
`define TTBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ttbc assertion failed");

`endif

/* design/ttbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbc_pkg
// Shared types, constants and code tables for the tick timers and button
// classifier.
// ----------------------------------------------------------------------------
package ttbc_pkg;

    // Operation codes of an input item
    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_LOAD_SENSOR  = 3'd1,
        OP_LOAD_SCROLL  = 3'd2,
        OP_START_BEEPER = 3'd3,
        OP_START_ALARM  = 3'd4,
        OP_READ_COMMAND = 3'd5
    } t_op;

    // Configuration register indexes
    localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
    localparam logic [1:0] REG_SHORT_PRESS      = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS       = 2'd2;

    // Register reset values
    localparam logic [7:0]  TPS_RESET   = 8'd250;
    localparam logic [14:0] SHORT_RESET = 15'd5;
    localparam logic [14:0] LONG_RESET  = 15'd150;

    // Command codes
    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_SHORT_B1 = 4'd1;
    localparam logic [3:0] CMD_SHORT_B2 = 4'd2;
    localparam logic [3:0] CMD_SHORT_B3 = 4'd3;
    localparam logic [3:0] CMD_LONG_B1  = 4'd4;
    localparam logic [3:0] CMD_LONG_B2  = 4'd5;
    localparam logic [3:0] CMD_LONG_B3  = 4'd6;
    localparam logic [3:0] CMD_LONG_B12 = 4'd7;
    localparam logic [3:0] CMD_LONG_B23 = 4'd8;
    localparam logic [3:0] CMD_LONG_B13 = 4'd9;

    // Button patterns
    localparam logic [2:0] PAT_B1  = 3'b001;
    localparam logic [2:0] PAT_B2  = 3'b010;
    localparam logic [2:0] PAT_B3  = 3'b100;
    localparam logic [2:0] PAT_B12 = 3'b011;
    localparam logic [2:0] PAT_B23 = 3'b110;
    localparam logic [2:0] PAT_B13 = 3'b101;

    // Timer constants
    localparam logic [14:0] HOLD_MAX     = 15'h7FFF;
    localparam logic [5:0]  ALARM_SEC_MAX = 6'd59;
    localparam logic [7:0]  BEEP_MASK    = 8'h0E;
    localparam logic [7:0]  BEEP_LIMIT   = 8'd8;

    // One accepted item as seen by the update logic
    typedef struct packed {
        logic       fire;
        logic [2:0] op;
        logic [2:0] buttons;
        logic [7:0] load_value;
    } t_step;

    // Timer side of a result
    typedef struct packed {
        logic       beeper_on;
        logic [7:0] sensor_count;
        logic [7:0] scroll_count;
    } t_timer_result;

    function automatic logic [3:0] long_code(input logic [2:0] pat);
        logic [3:0] code;
        case (pat)
            PAT_B1:  code = CMD_LONG_B1;
            PAT_B2:  code = CMD_LONG_B2;
            PAT_B3:  code = CMD_LONG_B3;
            PAT_B12: code = CMD_LONG_B12;
            PAT_B23: code = CMD_LONG_B23;
            PAT_B13: code = CMD_LONG_B13;
            default: code = CMD_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] short_code(input logic [2:0] pat);
        logic [3:0] code;
        case (pat)
            PAT_B1:  code = CMD_SHORT_B1;
            PAT_B2:  code = CMD_SHORT_B2;
            PAT_B3:  code = CMD_SHORT_B3;
            default: code = CMD_NONE;
        endcase
        return code;
    endfunction

endpackage

/* design/ttbc_button.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbc_button
// Hold counter, press classification and command mailbox.
// ----------------------------------------------------------------------------
module ttbc_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttbc_pkg::t_step   i_step,
    input  logic [14:0]       i_short_press,
    input  logic [14:0]       i_long_press,
    output logic [3:0]        o_command
);
    import ttbc_pkg::*;

    logic [14:0] r_hold, n_hold;
    logic [2:0]  r_last, n_last;
    logic [3:0]  r_mbox, n_mbox;
    logic [14:0] hold_inc;

    assign hold_inc = r_hold + 15'd1;

    // Next state and result command
    always_comb begin
        n_hold    = r_hold;
        n_last    = r_last;
        n_mbox    = r_mbox;
        o_command = CMD_NONE;
        case (i_step.op)
            OP_TICK: begin
                if (i_step.buttons != 3'd0) begin
                    if (i_step.buttons == r_last) begin
                        if (r_hold != HOLD_MAX) begin
                            n_hold = hold_inc;
                            // long press fires only when stepping onto threshold
                            if (hold_inc == i_long_press && long_code(r_last) != CMD_NONE) begin
                                n_mbox = long_code(r_last);
                            end
                        end
                    end else begin
                        // pattern change keeps the count
                        n_last = i_step.buttons;
                    end
                end else begin
                    // release
                    if (r_hold > i_short_press && r_hold < i_long_press &&
                        short_code(r_last) != CMD_NONE) begin
                        n_mbox = short_code(r_last);
                    end
                    n_hold = '0;
                end
            end
            OP_READ_COMMAND: begin
                o_command = r_mbox;
                n_mbox    = CMD_NONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_last <= '0;
            r_mbox <= CMD_NONE;
        end else if (i_step.fire) begin
            r_hold <= n_hold;
            r_last <= n_last;
            r_mbox <= n_mbox;
        end
    end

endmodule

/* design/ttbc_timers.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbc_timers
// Second prescaler, sensor and scroll countdowns, alarm and beeper pattern.
// ----------------------------------------------------------------------------
module ttbc_timers (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ttbc_pkg::t_step         i_step,
    input  logic [7:0]              i_ticks_per_second,
    output ttbc_pkg::t_timer_result o_result
);
    import ttbc_pkg::*;

    logic [7:0] r_pres, n_pres;
    logic [7:0] r_sensor, n_sensor;
    logic [7:0] r_scroll, n_scroll;
    logic [5:0] r_alarm_sec, n_alarm_sec;
    logic [7:0] r_alarm_min, n_alarm_min;
    logic [7:0] r_beep, n_beep;
    logic       r_pin_high, n_pin_high;
    logic       sec_event;

    assign sec_event = (r_pres == 8'd0);

    // Next state
    always_comb begin
        n_pres      = r_pres;
        n_sensor    = r_sensor;
        n_scroll    = r_scroll;
        n_alarm_sec = r_alarm_sec;
        n_alarm_min = r_alarm_min;
        n_beep      = r_beep;
        n_pin_high  = r_pin_high;
        case (i_step.op)
            OP_TICK: begin
                // prescaler and once-a-second countdowns
                if (!sec_event) begin
                    n_pres = r_pres - 8'd1;
                end else begin
                    n_pres = i_ticks_per_second;
                    if (r_sensor != 8'd0) n_sensor = r_sensor - 8'd1;
                    if (r_scroll != 8'd0) n_scroll = r_scroll - 8'd1;
                    if (r_alarm_sec != 6'd0) begin
                        n_alarm_sec = r_alarm_sec - 6'd1;
                    end else if (r_alarm_min != 8'd0) begin
                        n_alarm_min = r_alarm_min - 8'd1;
                        n_alarm_sec = ALARM_SEC_MAX;
                    end
                end
                // beep pattern reloads while the alarm runs
                if (r_beep != 8'd0) begin
                    n_beep = r_beep - 8'd1;
                end else if (n_alarm_sec != 6'd0 || n_alarm_min != 8'd0) begin
                    n_beep = i_ticks_per_second;
                end
                // pin: low in first half of second during the beep window, sticky
                if ((n_beep & BEEP_MASK) > BEEP_LIMIT) begin
                    if (n_pres > (i_ticks_per_second >> 1)) n_pin_high = 1'b0;
                end else begin
                    n_pin_high = 1'b1;
                end
            end
            OP_LOAD_SENSOR: n_sensor = i_step.load_value;
            OP_LOAD_SCROLL: n_scroll = i_step.load_value;
            OP_START_BEEPER: begin
                n_beep      = i_step.load_value;
                n_pres      = i_ticks_per_second;
                n_alarm_sec = '0;
                n_alarm_min = '0;
            end
            OP_START_ALARM: n_alarm_min = i_step.load_value;
            default: begin
            end
        endcase
    end

    assign o_result.beeper_on    = ~n_pin_high;
    assign o_result.sensor_count = n_sensor;
    assign o_result.scroll_count = n_scroll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pres      <= TPS_RESET;
            r_sensor    <= '0;
            r_scroll    <= '0;
            r_alarm_sec <= '0;
            r_alarm_min <= '0;
            r_beep      <= '0;
            r_pin_high  <= 1'b1;
        end else if (i_step.fire) begin
            r_pres      <= n_pres;
            r_sensor    <= n_sensor;
            r_scroll    <= n_scroll;
            r_alarm_sec <= n_alarm_sec;
            r_alarm_min <= n_alarm_min;
            r_beep      <= n_beep;
            r_pin_high  <= n_pin_high;
        end
    end

endmodule

/* design/tick_timers_and_button_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_timers_and_button_classifier
// Button press classifier and tick driven timers behind an input register
// and a result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | in        | i_in_valid/o_in_ready | operation, buttons, load_value
//   out     | out       | o_out_valid/i_out_ready | command, beeper_on,
//           |           |                       | sensor_count, scroll_count
//   cfg     | in        | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled.
// State updates happen as the item moves from the input register to the
// result register, in one pass of counter logic.
// Reset (synchronous, active low) empties both registers and restores
// all timers, the mailbox and the configuration registers.
// A stalled output holds its result; the input register still takes an
// item while empty, then waits. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module tick_timers_and_button_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [2:0]  i_buttons,
    input  logic [7:0]  i_load_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_command,
    output logic        o_beeper_on,
    output logic [7:0]  o_sensor_count,
    output logic [7:0]  o_scroll_count,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import ttbc_pkg::*;

    logic          r_in_valid;
    logic [2:0]    r_in_op;
    logic [2:0]    r_in_buttons;
    logic [7:0]    r_in_load;
    logic          r_out_valid;
    logic [3:0]    r_out_command;
    logic          r_out_beeper;
    logic [7:0]    r_out_sensor;
    logic [7:0]    r_out_scroll;
    logic [7:0]    r_tps;
    logic [14:0]   r_short;
    logic [14:0]   r_long;
    logic          out_free;
    logic          advance;
    t_step         step;
    t_timer_result timer_res;
    logic [3:0]    command;

    // Handshake control
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    assign step.fire       = advance;
    assign step.op         = r_in_op;
    assign step.buttons    = r_in_buttons;
    assign step.load_value = r_in_load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps   <= TPS_RESET;
            r_short <= SHORT_RESET;
            r_long  <= LONG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TICKS_PER_SECOND: r_tps   <= i_cfg_data[7:0];
                REG_SHORT_PRESS:      r_short <= i_cfg_data;
                REG_LONG_PRESS:       r_long  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op      <= i_operation;
            r_in_buttons <= i_buttons;
            r_in_load    <= i_load_value;
        end
    end

    ttbc_button u_button (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_short_press (r_short),
        .i_long_press  (r_long),
        .o_command     (command)
    );

    ttbc_timers u_timers (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_ticks_per_second (r_tps),
        .o_result           (timer_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_command <= command;
            r_out_beeper  <= timer_res.beeper_on;
            r_out_sensor  <= timer_res.sensor_count;
            r_out_scroll  <= timer_res.scroll_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command      = r_out_command;
    assign o_beeper_on    = r_out_beeper;
    assign o_sensor_count = r_out_sensor;
    assign o_scroll_count = r_out_scroll;

endmodule

/* design/ttbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttbc_checker
// Port-level checks for the tick timers and button classifier, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "tick_timers_and_button_classifier_macros.svh"

module ttbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_command
);

    // Only defined command codes reach the output
    `TTBC_ASSERT_NOW(a_cmd_range, o_out_valid, o_command <= 4'd9)

    // An empty result register never blocks the input
    `TTBC_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

    // An accepted item shows a valid result once past the input and result registers
    `TTBC_ASSERT_NEXT(a_latency, i_in_valid && o_in_ready, ##1 o_out_valid)

    // A stalled result stays put
    `TTBC_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_command))

endmodule

bind tick_timers_and_button_classifier ttbc_checker u_ttbc_checker (.*);

/* bench/tb_tick_timers_and_button_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_timers_and_button_classifier
// Self-checking bench for the button classifier and tick timers. A predictor
// class follows every accepted item and queues the expected result. Each
// result transfer is compared field by field against the oldest entry. The
// run has a short directed opener and then five register settings. In each
// setting, random press/hold/release runs are mixed with timer loads, beeper
// and alarm starts, mailbox reads and spare opcodes. One setting puts every
// register at its top value and holds a button well short of both
// thresholds. Both channels idle in random bursts, except during the final
// setting.
// ----------------------------------------------------------------------------
module tb_tick_timers_and_button_classifier;
    import ttbc_pkg::*;

    // Opcodes the block leaves unused, and the register index it ignores
    localparam logic [2:0] OP_SPARE6  = 3'd6;
    localparam logic [2:0] OP_SPARE7  = 3'd7;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [2:0] PAT_NONE   = 3'b000;
    localparam logic [2:0] PAT_ALL    = 3'b111;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [3:0] command;
        logic       beeper_on;
        logic [7:0] sensor_count;
        logic [7:0] scroll_count;
    } t_panel_result;

    // Predicts the panel state and holds the results still to come
    class button_timer_board;
        logic [7:0]  tps;
        logic [14:0] short_lim;
        logic [14:0] long_lim;
        logic [14:0] hold_count;
        logic [2:0]  last_pattern;
        logic [3:0]  mailbox;
        logic [7:0]  prescaler;
        logic [7:0]  sensor_left;
        logic [7:0]  scroll_left;
        logic [5:0]  alarm_sec;
        logic [7:0]  alarm_min;
        logic [7:0]  beep_left;
        logic        pin_high;
        t_panel_result expected_panels[$];
        int mismatches;

        function new();
            tps          = TPS_RESET;
            short_lim    = SHORT_RESET;
            long_lim     = LONG_RESET;
            hold_count   = '0;
            last_pattern = PAT_NONE;
            mailbox      = CMD_NONE;
            prescaler    = TPS_RESET;
            sensor_left  = '0;
            scroll_left  = '0;
            alarm_sec    = '0;
            alarm_min    = '0;
            beep_left    = '0;
            pin_high     = 1'b1;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [14:0] data);
            case (idx)
                REG_TICKS_PER_SECOND: tps = data[7:0];
                REG_SHORT_PRESS:      short_lim = data;
                REG_LONG_PRESS:       long_lim = data;
                default: ;
            endcase
        endfunction

        // Command code for a released (short) or held (long) pattern
        function logic [3:0] button_code(logic [2:0] pat, bit held_long);
            logic [3:0] code;
            code = CMD_NONE;
            if (held_long) begin
                case (pat)
                    PAT_B1:  code = CMD_LONG_B1;
                    PAT_B2:  code = CMD_LONG_B2;
                    PAT_B3:  code = CMD_LONG_B3;
                    PAT_B12: code = CMD_LONG_B12;
                    PAT_B23: code = CMD_LONG_B23;
                    PAT_B13: code = CMD_LONG_B13;
                    default: code = CMD_NONE;
                endcase
            end else begin
                case (pat)
                    PAT_B1:  code = CMD_SHORT_B1;
                    PAT_B2:  code = CMD_SHORT_B2;
                    PAT_B3:  code = CMD_SHORT_B3;
                    default: code = CMD_NONE;
                endcase
            end
            return code;
        endfunction

        function void apply_item(logic [2:0] op, logic [2:0] btn, logic [7:0] val);
            t_panel_result res;
            res.command = CMD_NONE;
            case (op)
                OP_TICK: begin
                    // press tracking; a new pattern keeps the count
                    if (btn != PAT_NONE) begin
                        if (btn == last_pattern) begin
                            if (hold_count != HOLD_MAX) begin
                                hold_count = hold_count + 15'd1;
                                if (hold_count == long_lim &&
                                        button_code(last_pattern, 1'b1) != CMD_NONE)
                                    mailbox = button_code(last_pattern, 1'b1);
                            end
                        end else begin
                            last_pattern = btn;
                        end
                    end else begin
                        if (hold_count > short_lim && hold_count < long_lim &&
                                button_code(last_pattern, 1'b0) != CMD_NONE)
                            mailbox = button_code(last_pattern, 1'b0);
                        hold_count = '0;
                    end
                    // one-second prescaler and the countdowns it drives
                    if (prescaler != 8'd0) begin
                        prescaler = prescaler - 8'd1;
                    end else begin
                        prescaler = tps;
                        if (sensor_left != 8'd0) sensor_left = sensor_left - 8'd1;
                        if (scroll_left != 8'd0) scroll_left = scroll_left - 8'd1;
                        if (alarm_sec != 6'd0) begin
                            alarm_sec = alarm_sec - 6'd1;
                        end else if (alarm_min != 8'd0) begin
                            alarm_min = alarm_min - 8'd1;
                            alarm_sec = ALARM_SEC_MAX;
                        end
                    end
                    // beeper pattern, pin level is sticky in the active window
                    if (beep_left != 8'd0)
                        beep_left = beep_left - 8'd1;
                    else if (alarm_sec != 6'd0 || alarm_min != 8'd0)
                        beep_left = tps;
                    if ((beep_left & BEEP_MASK) > BEEP_LIMIT) begin
                        if (prescaler > (tps >> 1)) pin_high = 1'b0;
                    end else begin
                        pin_high = 1'b1;
                    end
                end
                OP_LOAD_SENSOR: sensor_left = val;
                OP_LOAD_SCROLL: scroll_left = val;
                OP_START_BEEPER: begin
                    beep_left = val;
                    prescaler = tps;
                    alarm_sec = '0;
                    alarm_min = '0;
                end
                OP_START_ALARM: alarm_min = val;
                OP_READ_COMMAND: begin
                    res.command = mailbox;
                    mailbox = CMD_NONE;
                end
                default: ;
            endcase
            res.beeper_on    = ~pin_high;
            res.sensor_count = sensor_left;
            res.scroll_count = scroll_left;
            expected_panels.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] %s mismatch: expected %0d, got %0d",
                             $time, name, want, got);
            end
        endfunction

        function void compare_panel(t_panel_result got);
            t_panel_result want;
            if (expected_panels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result with nothing expected: %h", $time, got);
                return;
            end
            want = expected_panels.pop_front();
            compare_field("command", 8'(want.command), 8'(got.command));
            compare_field("beeper_on", 8'(want.beeper_on), 8'(got.beeper_on));
            compare_field("sensor_count", want.sensor_count, got.sensor_count);
            compare_field("scroll_count", want.scroll_count, got.scroll_count);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_operation = OP_TICK;
    logic [2:0]  i_buttons = PAT_NONE;
    logic [7:0]  i_load_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_command;
    logic        o_beeper_on;
    logic [7:0]  o_sensor_count;
    logic [7:0]  o_scroll_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_TICKS_PER_SECOND;
    logic [14:0] i_cfg_data = '0;

    button_timer_board board;
    bit calm = 1'b1;
    int items_sent = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    tick_timers_and_button_classifier u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_buttons      (i_buttons),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_command      (o_command),
        .o_beeper_on    (o_beeper_on),
        .o_sensor_count (o_sensor_count),
        .o_scroll_count (o_scroll_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Result side backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 24) == 0)
                stall_left = $urandom_range(1, 16);
        end
    end

    // Result check and watchdog on transfer activity
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.compare_panel({o_command, o_beeper_on, o_sensor_count, o_scroll_count});
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                    (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_item(input logic [2:0] op, input logic [2:0] btn,
                             input logic [7:0] val);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_buttons    <= btn;
        i_load_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.apply_item(op, btn, val);
        items_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (board.expected_panels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Reprogram all registers with the block idle
    task automatic start_phase(input logic [14:0] tps_data, input logic [14:0] short_data,
                               input logic [14:0] long_data);
        wait_drain();
        write_reg(REG_TICKS_PER_SECOND, tps_data);
        write_reg(REG_SHORT_PRESS, short_data);
        write_reg(REG_LONG_PRESS, long_data);
        write_reg(REG_UNUSED, 15'($urandom_range(0, 15'h7FFF)));
        i_cfg_valid <= 1'b0;
    endtask

    // Hold a pattern around the thresholds, maybe switch it, then usually release
    task automatic press_run(input int cap);
        logic [2:0] pat;
        int hold;
        int flip_at;
        int pick;
        int short_ticks;
        int long_ticks;
        short_ticks = int'(board.short_lim);
        long_ticks  = int'(board.long_lim);
        pat  = 3'($urandom_range(1, 7));
        pick = $urandom_range(0, 2);
        if (pick == 0)
            hold = $urandom_range(0, (short_ticks + 3 < cap) ? short_ticks + 3 : cap);
        else if (pick == 1 && long_ticks + 3 <= cap)
            hold = $urandom_range(long_ticks - 1, long_ticks + 3);
        else
            hold = $urandom_range(0, cap);
        flip_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, hold) : -1;
        for (int i = 0; i < hold; i++) begin
            if (i == flip_at) pat = 3'($urandom_range(1, 7));
            send_item(OP_TICK, pat, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) != 0)
            send_item(OP_TICK, PAT_NONE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1)
            send_item(OP_READ_COMMAND, 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
    endtask

    // Press runs mixed with timer operations and noise
    task automatic run_phase(input int target, input int cap, input bit keep_calm);
        int first;
        first = items_sent;
        while (items_sent < first + target) begin
            calm = (items_sent < first + target / 4) ? 1'b1 : keep_calm;
            press_run(cap);
            if ($urandom_range(0, 2) == 0)
                send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                send_item(3'($urandom_range(OP_LOAD_SENSOR, OP_START_ALARM)),
                          3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opener at reset settings
        calm = 1'b1;
        send_item(OP_LOAD_SENSOR, PAT_NONE, 8'hFF);
        send_item(OP_LOAD_SCROLL, PAT_ALL, 8'hFF);
        send_item(OP_START_ALARM, PAT_NONE, 8'd1);
        send_item(OP_TICK, PAT_ALL, 8'h00);
        send_item(OP_TICK, PAT_ALL, 8'hFF);
        send_item(OP_TICK, PAT_B13, 8'h00);
        send_item(OP_TICK, PAT_NONE, 8'h00);
        send_item(OP_READ_COMMAND, PAT_ALL, 8'hFF);
        send_item(OP_SPARE6, PAT_ALL, 8'hFF);
        send_item(OP_SPARE7, PAT_NONE, 8'h00);
        send_item(OP_START_BEEPER, PAT_NONE, 8'h0F);
        send_item(OP_TICK, PAT_B1, 8'h00);
        send_item(OP_TICK, PAT_B1, 8'h00);
        send_item(OP_TICK, PAT_B1, 8'h00);
        send_item(OP_TICK, PAT_NONE, 8'h00);
        send_item(OP_READ_COMMAND, PAT_NONE, 8'h00);
        send_item(OP_START_ALARM, PAT_NONE, 8'hFF);
        send_item(OP_TICK, PAT_B2, 8'h00);
        send_item(OP_LOAD_SENSOR, PAT_NONE, 8'h00);
        send_item(OP_LOAD_SCROLL, PAT_NONE, 8'h00);
        send_item(OP_TICK, PAT_B3, 8'h00);
        send_item(OP_READ_COMMAND, PAT_NONE, 8'h00);
        // sender holds off until every result is back
        wait_drain();
        run_phase(120, 200, 1'b0);

        // Lowest thresholds and a small prescaler
        start_phase(15'd2, 15'd0, 15'd1);
        run_phase(120, 40, 1'b0);

        // Prescaler written out of range through the upper data bits
        start_phase(15'h7F00, 15'd3, 15'd12);
        run_phase(120, 60, 1'b0);

        // Top of every register; a long hold reaches neither threshold
        start_phase(15'h7FFF, 15'h7FFF, 15'h7FFF);
        calm = 1'b1;
        send_item(OP_TICK, PAT_NONE, 8'h00);
        for (int i = 0; i < 40; i++)
            send_item(OP_TICK, PAT_B2, 8'h00);
        send_item(OP_READ_COMMAND, PAT_NONE, 8'h00);
        for (int i = 0; i < 20; i++)
            send_item(OP_TICK, PAT_B2, 8'h00);
        send_item(OP_READ_COMMAND, PAT_NONE, 8'h00);
        send_item(OP_TICK, PAT_NONE, 8'h00);
        send_item(OP_READ_COMMAND, PAT_NONE, 8'h00);
        run_phase(120, 200, 1'b0);

        // Mid settings, no idling on either side
        start_phase(15'd20, 15'd4, 15'd40);
        calm = 1'b1;
        run_phase(120, 60, 1'b1);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_panels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/ttbc_pkg.sv
design/ttbc_button.sv
design/ttbc_timers.sv
design/tick_timers_and_button_classifier.sv
design/ttbc_checker.sv
bench/tb_tick_timers_and_button_classifier.sv
